@@ sv/sags_pkg.sv @@
package sags_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int FRACTION_BITS = 16;
  localparam int NAXES         = 3;
  localparam int STEP_W        = 16;
  localparam int TICK_W        = 16;
  localparam int CTR_W         = 17;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int IVL_W         = TICK_W + FRACTION_BITS;
  localparam int MARK_W        = CTR_W + FRACTION_BITS + 1;
  localparam int DIV_CNT_W     = $clog2(IVL_W + 1);

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0]                ticks;
    logic [NAXES-1:0]                 dir;
    logic [NAXES-1:0][STEP_W-1:0]     steps;
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } sags_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ sv/sags_if.sv @@
interface sags_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] segment_ticks;
  logic [15:0] steps_first;
  logic [15:0] steps_second;
  logic [15:0] steps_third;
  logic        dir_first;
  logic        dir_second;
  logic        dir_third;
  logic        endstop_first;
  logic        endstop_second;
  logic        endstop_third;

  modport source (output valid, opcode, segment_ticks, steps_first, steps_second,
                  steps_third, dir_first, dir_second, dir_third, endstop_first,
                  endstop_second, endstop_third, input ready);
  modport sink (input valid, opcode, segment_ticks, steps_first, steps_second,
                steps_third, dir_first, dir_second, dir_third, endstop_first,
                endstop_second, endstop_third, output ready);
endinterface

interface sags_out_if;
  logic       valid;
  logic       ready;
  logic       step_pulse_first;
  logic       step_pulse_second;
  logic       step_pulse_third;
  logic       direction_first;
  logic       direction_second;
  logic       direction_third;
  logic       is_running;
  logic       push_rejected;
  logic [4:0] queued_segments;

  modport source (output valid, step_pulse_first, step_pulse_second, step_pulse_third,
                  direction_first, direction_second, direction_third, is_running,
                  push_rejected, queued_segments, input ready);
  modport sink (input valid, step_pulse_first, step_pulse_second, step_pulse_third,
                direction_first, direction_second, direction_third, is_running,
                push_rejected, queued_segments, output ready);
endinterface

interface sags_cfg_if;
  logic valid;
  logic ready;
  logic homing_mode;

  modport source (output valid, homing_mode, input ready);
  modport sink (input valid, homing_mode, output ready);
endinterface

@@ sv/sags_div.sv @@
module sags_div
  import sags_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             ctrl_i,
  input  logic [IVL_W-1:0]      dividend_i,
  input  logic [STEP_W-1:0]     divisor_i,
  output div_stat_t             stat_o,
  output logic [IVL_W-1:0]      quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [STEP_W-1:0]    rem_q, rem_d;
  logic [IVL_W-1:0]     quo_q, quo_d;
  logic [STEP_W:0]      shifted;
  logic                 ge;

  // one restoring step per cycle, quotient bits shift in at the bottom
  always_comb begin
    shifted = {rem_q, quo_q[IVL_W-1]};
    ge      = shifted >= {1'b0, divisor_i};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(IVL_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? STEP_W'(shifted - {1'b0, divisor_i}) : shifted[STEP_W-1:0];
      quo_d = {quo_q[IVL_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ sv/three_axis_segment_step_generator_unit.sv @@
// Three-axis segment step generator. Push items queue motion segments (up to
// QUEUE_DEPTH, a push into a full queue is dropped and flagged), a start item
// loads the oldest one, and each tick item while running advances the tick
// counter and pulses each axis with steps left whose 18.16 next-step mark has
// fallen below the counter. Every item returns exactly one result beat with
// the pulses, the direction levels, the running flag, the reject flag and the
// queue fill. Push, start without a load and tick without a load are answered
// in the idle state. An item that loads a segment (a start, or the tick that
// finishes a segment while more are queued) walks the read, load, issue and
// wait states: the shared restoring divider computes the three step intervals
// one after the other, one quotient bit per cycle; an axis with no
// steps skips the divider. The input is not ready while a load is running.
// The output register lets the next item be accepted in the cycle its
// predecessor's result is taken. The homing_mode register is written through
// its own channel, which is always ready.
module three_axis_segment_step_generator_unit
  import sags_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sags_in_if.sink     in_i,
  sags_out_if.source  out_o,
  sags_cfg_if.sink    cfg_i
);

  // queue storage
  seg_t queue_mem [QUEUE_DEPTH];
  seg_t rd_q;
  seg_t wr_seg;
  logic mem_we;

  sags_state_e state_q, state_d;
  logic [1:0]       axis_q, axis_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CTR_W-1:0] counter_q, counter_d, cnt_n;
  logic [TICK_W-1:0] seg_ticks_q, seg_ticks_d;
  logic [IVL_W-1:0]  interval_q [NAXES];
  logic [IVL_W-1:0]  interval_d [NAXES];
  logic [MARK_W-1:0] mark_q [NAXES];
  logic [MARK_W-1:0] mark_d [NAXES];
  logic [MARK_W-1:0] now;
  logic [STEP_W-1:0] steps_q [NAXES];
  logic [STEP_W-1:0] steps_d [NAXES];
  logic [STEP_W-1:0] steps_h [NAXES];
  logic [NAXES-1:0]  dir_q, dir_d;
  logic [NAXES-1:0]  pulse_q, pulse_d;
  logic [NAXES-1:0]  fire, tick_pulse, endstop;
  logic              running_q, running_d;
  logic              homing_q, homing_d;
  logic              hmode_q;
  logic              halted, all_done, in_acc, load_go, res_set;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [NAXES-1:0]  out_pulse_q, out_dir_q;
  logic              out_run_q, out_rej_q, res_rej;
  logic [CNT_W-1:0]  out_cnt_q;

  div_ctrl_t         div_ctrl;
  div_stat_t         div_stat;
  logic [IVL_W-1:0]  quotient;

  sags_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i ({seg_ticks_q, FRACTION_BITS'(0)}),
    .divisor_i  (steps_q[axis_q]),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign div_ctrl.start = (state_q == ST_ISSUE) && (steps_q[axis_q] != '0);

  assign endstop = {in_i.endstop_third, in_i.endstop_second, in_i.endstop_first};
  assign wr_seg.ticks    = in_i.segment_ticks;
  assign wr_seg.dir      = {in_i.dir_third, in_i.dir_second, in_i.dir_first};
  assign wr_seg.steps[0] = in_i.steps_first;
  assign wr_seg.steps[1] = in_i.steps_second;
  assign wr_seg.steps[2] = in_i.steps_third;

  // write slot = head + count, wrapped
  always_comb begin
    tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
  end

  // tick evaluation on the current axis state
  always_comb begin
    halted = homing_q && (&endstop);
    cnt_n  = (&counter_q) ? counter_q : counter_q + 1'b1;
    now    = MARK_W'({cnt_n, FRACTION_BITS'(0)});
    for (int a = 0; a < NAXES; a++) begin
      steps_h[a]    = (homing_q && endstop[a]) ? '0 : steps_q[a];
      fire[a]       = mark_q[a] < now;
      tick_pulse[a] = fire[a] && (steps_h[a] != '0);
    end
    all_done = 1'b1;
    for (int a = 0; a < NAXES; a++) begin
      if (steps_h[a] != STEP_W'(tick_pulse[a])) begin
        all_done = 1'b0;
      end
    end
  end

  // a segment load starts on a start item, or on the tick that ends a segment
  always_comb begin
    load_go = 1'b0;
    if (in_acc) begin
      case (in_i.opcode)
        OP_START: load_go = !running_q && (count_q != '0);
        OP_TICK:  load_go = running_q && !halted && all_done && (count_q != '0);
        default:  load_go = 1'b0;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (load_go) state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_ISSUE;
      ST_ISSUE: begin
        if (steps_q[axis_q] != '0) begin
          state_d = ST_WAIT;
        end else if (axis_q == 2'(NAXES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          state_d = (axis_q == 2'(NAXES - 1)) ? ST_IDLE : ST_ISSUE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    axis_d      = axis_q;
    head_d      = head_q;
    count_d     = count_q;
    counter_d   = counter_q;
    seg_ticks_d = seg_ticks_q;
    interval_d  = interval_q;
    mark_d      = mark_q;
    steps_d     = steps_q;
    dir_d       = dir_q;
    pulse_d     = pulse_q;
    running_d   = running_q;
    homing_d    = homing_q;
    mem_we      = 1'b0;
    res_set     = 1'b0;
    res_rej     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pulse_d = '0;
          case (in_i.opcode)
            OP_PUSH: begin
              if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
                res_rej = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
              res_set = 1'b1;
            end
            OP_START: begin
              if (load_go) begin
                running_d = 1'b1;
                homing_d  = hmode_q;
              end else begin
                res_set = 1'b1;
              end
            end
            OP_TICK: begin
              if (running_q) begin
                steps_d = steps_h;
                if (halted) begin
                  running_d = 1'b0;
                  homing_d  = 1'b0;
                end else begin
                  counter_d = cnt_n;
                  pulse_d   = tick_pulse;
                  for (int a = 0; a < NAXES; a++) begin
                    if (fire[a]) begin
                      mark_d[a] = mark_q[a] + MARK_W'(interval_q[a]);
                    end
                    steps_d[a] = steps_h[a] - STEP_W'(tick_pulse[a]);
                  end
                  if (all_done && (count_q == '0)) begin
                    running_d = 1'b0;
                    homing_d  = 1'b0;
                    counter_d = '0;
                  end
                end
              end
              res_set = !load_go;
            end
            default: res_set = 1'b1;
          endcase
        end
      end
      ST_LOAD: begin
        seg_ticks_d = rd_q.ticks;
        dir_d       = rd_q.dir;
        for (int a = 0; a < NAXES; a++) begin
          steps_d[a] = rd_q.steps[a];
          mark_d[a]  = '0;
        end
        counter_d = '0;
        head_d    = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_d   = count_q - 1'b1;
        axis_d    = '0;
      end
      ST_ISSUE: begin
        if (steps_q[axis_q] == '0) begin
          interval_d[axis_q] = '0;
          if (axis_q == 2'(NAXES - 1)) begin
            res_set = 1'b1;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          interval_d[axis_q] = quotient;
          if (axis_q == 2'(NAXES - 1)) begin
            res_set = 1'b1;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
    // drop a taken beat, then load a fresh one
    out_valid_d = (out_valid_q && !out_o.ready) || res_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      head_q      <= '0;
      count_q     <= '0;
      counter_q   <= '0;
      running_q   <= 1'b0;
      homing_q    <= 1'b0;
      hmode_q     <= 1'b0;
      out_valid_q <= 1'b0;
      dir_q       <= '0;
      for (int a = 0; a < NAXES; a++) begin
        interval_q[a] <= '0;
        mark_q[a]     <= '0;
        steps_q[a]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      head_q      <= head_d;
      count_q     <= count_d;
      counter_q   <= counter_d;
      running_q   <= running_d;
      homing_q    <= homing_d;
      out_valid_q <= out_valid_d;
      dir_q       <= dir_d;
      interval_q  <= interval_d;
      mark_q      <= mark_d;
      steps_q     <= steps_d;
      if (cfg_i.valid && cfg_i.ready) begin
        hmode_q <= cfg_i.homing_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_ticks_q <= seg_ticks_d;
    pulse_q     <= pulse_d;
    rd_q        <= queue_mem[head_q];
    if (mem_we) begin
      queue_mem[tail] <= wr_seg;
    end
    if (res_set) begin
      out_pulse_q <= pulse_d;
      out_dir_q   <= dir_d;
      out_run_q   <= running_d;
      out_rej_q   <= res_rej;
      out_cnt_q   <= count_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.step_pulse_first  = out_pulse_q[0];
  assign out_o.step_pulse_second = out_pulse_q[1];
  assign out_o.step_pulse_third  = out_pulse_q[2];
  assign out_o.direction_first   = out_dir_q[0];
  assign out_o.direction_second  = out_dir_q[1];
  assign out_o.direction_third   = out_dir_q[2];
  assign out_o.is_running        = out_run_q;
  assign out_o.push_rejected     = out_rej_q;
  assign out_o.queued_segments   = 5'(out_cnt_q);

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_WAIT) && !div_stat.busy)
    else $error("divider finished outside wait state");

  a_homing_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    homing_q |-> running_q)
    else $error("homing active while stopped");

  a_load_keeps_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> running_q && !in_i.ready)
    else $error("segment load lost running or opened input");

endmodule

@@ tb/sags_tb_if.sv @@
`timescale 1ns / 100ps

// Channel bundles are taken from the design's interface file; this file only
// holds the result record that the scoreboard compares field by field.
package sags_tb_pkg;

  typedef struct {
    bit [2:0] pulse;
    bit [2:0] dir;
    bit       running;
    bit       rejected;
    bit [4:0] queued;
  } status_beat_t;

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// Step generator predictor: a software copy of the segment queue, the per-axis
// intervals and marks, and the running and homing flags.
class step_scoreboard;
  bit [15:0] seg_ticks [16];
  bit [15:0] seg_steps [16][3];
  bit        seg_dir [16][3];
  int unsigned head, count, counter;
  bit [63:0] interval [3];
  bit [63:0] mark [3];
  int unsigned left [3];
  bit        dir [3];
  bit        running, homing, homing_mode;
  sags_tb_pkg::status_beat_t pending [$];
  int errors;

  function void clear();
    head = 0; count = 0; counter = 0;
    for (int a = 0; a < 3; a++) begin
      interval[a] = 0; mark[a] = 0; left[a] = 0; dir[a] = 0;
    end
    running = 0; homing = 0; homing_mode = 0;
    pending.delete();
    errors = 0;
  endfunction

  function void load_next();
    int unsigned s;
    s = head;
    head = (head + 1) % 16;
    count--;
    for (int a = 0; a < 3; a++) begin
      left[a] = seg_steps[s][a];
      dir[a] = seg_dir[s][a];
      mark[a] = 0;
      interval[a] = left[a] != 0 ? ({48'd0, seg_ticks[s]} << 16) / left[a] : 0;
    end
    counter = 0;
  endfunction

  // Note one accepted input beat and queue the status it must produce.
  function void note_input(bit [1:0] op, bit [15:0] ticks, bit [15:0] st [3],
                           bit [2:0] dr, bit [2:0] es);
    sags_tb_pkg::status_beat_t r;
    bit halted;
    bit [63:0] now;
    int slot, hits;
    r.pulse = 0;
    r.rejected = 0;
    if (op == sags_pkg::OP_PUSH) begin
      if (count >= 16) begin
        r.rejected = 1;
      end else begin
        slot = (head + count) % 16;
        seg_ticks[slot] = ticks;
        for (int a = 0; a < 3; a++) begin
          seg_steps[slot][a] = st[a];
          seg_dir[slot][a] = dr[a];
        end
        count++;
      end
    end else if (op == sags_pkg::OP_START) begin
      if (!running && count > 0) begin
        load_next();
        running = 1;
        homing = homing_mode;
      end
    end else if (op == sags_pkg::OP_TICK && running) begin
      halted = 0;
      if (homing) begin
        hits = 0;
        for (int a = 0; a < 3; a++) begin
          if (es[a]) begin
            left[a] = 0;
            hits++;
          end
        end
        if (hits == 3) begin
          homing = 0; running = 0; halted = 1;
        end
      end
      if (!halted) begin
        if (counter < 'h1FFFF) counter++;
        now = 64'(counter) << 16;
        for (int a = 0; a < 3; a++) begin
          if (mark[a] < now) begin
            mark[a] += interval[a];
            if (left[a] != 0) begin
              left[a]--;
              r.pulse[a] = 1;
            end
          end
        end
        if (left[0] == 0 && left[1] == 0 && left[2] == 0) begin
          if (count > 0) begin
            load_next();
          end else begin
            running = 0; homing = 0; counter = 0;
          end
        end
      end
    end
    for (int a = 0; a < 3; a++) r.dir[a] = dir[a];
    r.running = running;
    r.queued = count[4:0];
    pending.push_back(r);
  endfunction

  // Compare one output beat against the oldest expected status.
  function void check_result(sags_tb_pkg::status_beat_t got);
    sags_tb_pkg::status_beat_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected status beat pulse=%b run=%b", $time, got.pulse,
               got.running);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.pulse != want.pulse) begin
      $display("%0t: pulse expected %b actual %b", $time, want.pulse, got.pulse);
      errors++;
    end
    if (got.dir != want.dir) begin
      $display("%0t: direction expected %b actual %b", $time, want.dir, got.dir);
      errors++;
    end
    if (got.running != want.running) begin
      $display("%0t: running expected %b actual %b", $time, want.running,
               got.running);
      errors++;
    end
    if (got.rejected != want.rejected) begin
      $display("%0t: rejected expected %b actual %b", $time, want.rejected,
               got.rejected);
      errors++;
    end
    if (got.queued != want.queued) begin
      $display("%0t: queued expected %0d actual %0d", $time, want.queued,
               got.queued);
      errors++;
    end
  endfunction
endclass

module testbench;
  import sags_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;

  sags_in_if  in_ch ();
  sags_out_if out_ch ();
  sags_cfg_if cfg_ch ();

  three_axis_segment_step_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  step_scoreboard board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Drive every input to a known value before reset releases.
  initial begin
    in_ch.valid = 0;
    in_ch.opcode = OP_TICK;
    in_ch.segment_ticks = 0;
    in_ch.steps_first = 0;
    in_ch.steps_second = 0;
    in_ch.steps_third = 0;
    in_ch.dir_first = 0;
    in_ch.dir_second = 0;
    in_ch.dir_third = 0;
    in_ch.endstop_first = 0;
    in_ch.endstop_second = 0;
    in_ch.endstop_third = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.homing_mode = 0;
  end

  // Receiver side: random stall on ready, check every accepted beat.
  always @(posedge clk_i) begin
    sags_tb_pkg::status_beat_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.pulse = {out_ch.step_pulse_third, out_ch.step_pulse_second,
                     out_ch.step_pulse_first};
        got.dir = {out_ch.direction_third, out_ch.direction_second,
                   out_ch.direction_first};
        got.running = out_ch.is_running;
        got.rejected = out_ch.push_rejected;
        got.queued = out_ch.queued_segments;
        board.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Send one beat; hold valid across back-to-back beats, drop only on a gap.
  task automatic send_beat(bit [1:0] op, bit [15:0] ticks, bit [15:0] st [3],
                           bit [2:0] dr, bit [2:0] es);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.segment_ticks <= ticks;
    in_ch.steps_first <= st[0];
    in_ch.steps_second <= st[1];
    in_ch.steps_third <= st[2];
    in_ch.dir_first <= dr[0];
    in_ch.dir_second <= dr[1];
    in_ch.dir_third <= dr[2];
    in_ch.endstop_first <= es[0];
    in_ch.endstop_second <= es[1];
    in_ch.endstop_third <= es[2];
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(op, ticks, st, dr, es);
  endtask

  task automatic idle_input();
    in_ch.valid <= 0;
    @(posedge clk_i);
  endtask

  // Wait for every expected beat, then let any load still running finish.
  task automatic drain();
    idle_input();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_homing(bit mode);
    cfg_ch.valid <= 1;
    cfg_ch.homing_mode <= mode;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    board.homing_mode = mode;
  endtask

  task automatic push_seg(bit [15:0] ticks, bit [15:0] s0, bit [15:0] s1,
                          bit [15:0] s2, bit [2:0] dr);
    bit [15:0] st [3];
    st[0] = s0; st[1] = s1; st[2] = s2;
    send_beat(OP_PUSH, ticks, st, dr, 3'b000);
  endtask

  // Mostly small step counts keep segments short; a few reach the extremes,
  // but only where homing end stops can cut such a segment short.
  function automatic bit [15:0] pick_steps(bit wide);
    int r;
    r = $urandom_range(99);
    if (r < 15) return 16'd0;
    if (r < 90) return 16'($urandom_range(6, 1));
    if (r < 97 || !wide) return 16'($urandom_range(40, 7));
    return 16'(16'hFFFF - $urandom_range(3));
  endfunction

  // Random payload; a push outside homing keeps its segment short.
  task automatic ctrl_beat(bit [1:0] op, bit [2:0] es);
    bit [15:0] st [3];
    bit [15:0] ticks;
    bit wide;
    wide = board.homing_mode || (op != OP_PUSH);
    ticks = wide ? 16'($urandom) : 16'($urandom_range(12));
    for (int a = 0; a < 3; a++) st[a] = wide ? 16'($urandom) : pick_steps(1'b0);
    send_beat(op, ticks, st, 3'($urandom), es);
  endtask

  // One run: a few segments, a start, then at most 120 beats, mostly ticks.
  task automatic random_run(ref int beats);
    int nseg, nticks;
    bit [2:0] es;
    bit wide;
    nseg = $urandom_range(4, 1);
    wide = board.homing_mode;
    for (int i = 0; i < nseg; i++) begin
      push_seg(($urandom_range(99) < 70 || !wide) ? 16'($urandom_range(12))
                                                   : 16'($urandom),
               pick_steps(wide), pick_steps(wide), pick_steps(wide), 3'($urandom));
      beats++;
    end
    ctrl_beat(OP_START, 0);
    beats++;
    nticks = 0;
    while (board.running && nticks < 120) begin
      es = $urandom_range(99) < 10 ? 3'($urandom) : 3'b000;
      if ($urandom_range(99) < 4) ctrl_beat(2'($urandom_range(3)), es);
      else ctrl_beat(OP_TICK, es);
      beats++;
      nticks++;
    end
  endtask

  // Set the stall rates and homing mode, then random runs and items to the target.
  task automatic run_phase(int sidle, int ridle, int target, bit mode);
    int beats;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    write_homing(mode);
    beats = 0;
    while (beats < target) begin
      if ($urandom_range(99) < 8) begin
        ctrl_beat(2'($urandom_range(3)), 3'($urandom));
        beats++;
      end else begin
        random_run(beats);
      end
    end
    // Finish whatever is still queued so the next phase starts stopped.
    while (board.running || board.count != 0) begin
      if (!board.running) ctrl_beat(OP_START, 0);
      else ctrl_beat(OP_TICK, 3'b111);
    end
    drain();
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: stopped tick, empty start, unknown opcode, then a full queue.
    ctrl_beat(OP_TICK, 3'b000);
    ctrl_beat(OP_START, 3'b000);
    ctrl_beat(2'd3, 3'b111);
    push_seg(16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 3'b111);
    push_seg(16'd0, 16'd2, 16'd3, 16'd0, 3'b010);
    push_seg(16'd1, 16'd0, 16'd0, 16'd0, 3'b000);
    push_seg(16'd5, 16'd1, 16'd1, 16'd1, 3'b101);
    for (int i = 0; i < 13; i++) push_seg(16'($urandom), 1, 0, 0, 3'($urandom));
    // Enter homing before the start so the end stops below take effect.
    drain();
    write_homing(1);
    ctrl_beat(OP_START, 3'b000);
    ctrl_beat(OP_START, 3'b000);
    push_seg(16'd3, 16'd1, 16'd2, 16'd3, 3'b011);
    // Sender holds off until all results are back.
    drain();
    // Homing: every end stop stops the block; the queue is kept.
    ctrl_beat(OP_START, 3'b000);
    ctrl_beat(OP_TICK, 3'b001);
    ctrl_beat(OP_TICK, 3'b111);
    drain();
    write_homing(0);

    run_phase(25, 59, 500, 0);
    run_phase(59, 25, 500, 1);
    run_phase(0, 0, 500, 0);

    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/sags_pkg.sv
sv/sags_if.sv
sv/sags_div.sv
sv/three_axis_segment_step_generator_unit.sv
tb/sags_tb_if.sv
tb/testbench.sv
